// ----- hdl/ehc_pkg.sv -----
// shared types and constants for the ethernet ip header classifier
`timescale 1ns / 1ps

package ehc_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 17;
    localparam int INDEX_W = 6;
    localparam int START_W = 5;
    localparam int TYPE_W  = 16;

    localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 17'd65536;
    localparam logic [INDEX_W-1:0] INDEX_MAX     = 6'd63;

    // byte positions of the type fields and the headers that follow them
    localparam logic [INDEX_W-1:0] IDX_OUTER_TYPE = 6'd13;
    localparam logic [INDEX_W-1:0] IDX_VLAN1_TYPE = 6'd17;
    localparam logic [INDEX_W-1:0] IDX_VLAN2_TYPE = 6'd21;
    localparam logic [START_W-1:0] POS_AFTER_MAC   = 5'd14;
    localparam logic [START_W-1:0] POS_AFTER_VLAN1 = 5'd18;
    localparam logic [START_W-1:0] POS_AFTER_VLAN2 = 5'd22;
    localparam logic [START_W-1:0] PPPOE_PROTO_OFS = 5'd7;
    localparam logic [START_W-1:0] PPPOE_HDR_LEN   = 5'd8;
    localparam logic [START_W-1:0] IPV4_LEN_OFS    = 5'd3;
    localparam logic [START_W-1:0] IPV6_LEN_OFS    = 5'd5;
    localparam logic [LEN_W-1:0]   IPV6_HDR_LEN    = 17'd40;
    localparam logic [3:0]         VER_FOUR        = 4'd4;
    localparam logic [3:0]         VER_SIX         = 4'd6;

    // ethertypes
    localparam logic [TYPE_W-1:0] ETH_VLAN     = 16'h8100;
    localparam logic [TYPE_W-1:0] ETH_SKIP_A   = 16'h9998;
    localparam logic [TYPE_W-1:0] ETH_SKIP_B   = 16'h88a7;
    localparam logic [TYPE_W-1:0] ETH_LLDP     = 16'h88cc;
    localparam logic [TYPE_W-1:0] ETH_PPPOE_S  = 16'h8864;
    localparam logic [TYPE_W-1:0] ETH_PPPOE_D  = 16'h8863;
    localparam logic [TYPE_W-1:0] ETH_IPV4     = 16'h0800;
    localparam logic [TYPE_W-1:0] ETH_IPV6     = 16'h86dd;
    localparam logic [TYPE_W-1:0] ETH_ARP      = 16'h0806;
    localparam logic [TYPE_W-1:0] ETH_SKIP_C   = 16'h0027;

    // ppp protocols
    localparam logic [TYPE_W-1:0] PPP_IPV4     = 16'h0021;
    localparam logic [TYPE_W-1:0] PPP_IPV6     = 16'h0057;
    localparam logic [TYPE_W-1:0] PPP_IPV6CP   = 16'h8057;
    localparam logic [TYPE_W-1:0] PPP_LCP      = 16'hc021;
    localparam logic [TYPE_W-1:0] PPP_SKIP_A   = 16'h0101;
    localparam logic [TYPE_W-1:0] PPP_PAP      = 16'hc023;
    localparam logic [TYPE_W-1:0] PPP_SKIP_B   = 16'hc022;
    localparam logic [TYPE_W-1:0] PPP_IPCP     = 16'h8021;

    typedef enum logic [2:0] {
        ST_IPV4    = 3'd0,
        ST_IPV6    = 3'd1,
        ST_SKIP    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_BADVER  = 3'd4,
        ST_TOOLONG = 3'd5,
        ST_TRUNC   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        STG_OUTER = 3'd0,
        STG_VLAN1 = 3'd1,
        STG_VLAN2 = 3'd2,
        STG_PPP   = 3'd3,
        STG_IP    = 3'd4,
        STG_DONE  = 3'd5
    } t_stage;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [LEN_W-1:0] packet_len;
    } t_out_word;

    // decision taken on the type that follows the mac header or vlan tags
    typedef struct packed {
        t_stage  stage;
        t_status verdict;
        logic    v6;
    } t_type_decode;

endpackage

// ----- hdl/ehc_parser.sv -----
// per-byte header parser with frame state and result register
`timescale 1ns / 1ps

module ehc_parser import ehc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_in_word         i_word,
    input  logic [LEN_W-1:0] i_max_len,
    output logic             o_take,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word
);

    logic [INDEX_W-1:0] r_index, n_index;
    logic [TYPE_W-1:0]  r_shift, n_shift;
    t_stage             r_stage, n_stage;
    logic [START_W-1:0] r_start, n_start;
    logic [LEN_W-1:0]   r_len, n_len;
    t_status            r_verdict, n_verdict;
    logic               r_v6, n_v6;
    logic               r_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic               w_fire;
    logic               w_slot_free;
    logic [LEN_W-1:0]   w_total;
    logic [INDEX_W-1:0] w_len_idx;
    t_type_decode       w_dec;
    t_status            w_status;

    function automatic t_type_decode decode_type(input logic [TYPE_W-1:0] t);
        t_type_decode d;
        d.stage   = STG_DONE;
        d.verdict = ST_UNKNOWN;
        d.v6      = 1'b0;
        if (t == ETH_PPPOE_S) begin
            d.stage = STG_PPP;
        end else if (t == ETH_IPV4) begin
            d.stage = STG_IP;
        end else if (t == ETH_IPV6) begin
            d.stage = STG_IP;
            d.v6    = 1'b1;
        end else if (t == ETH_ARP || t == ETH_PPPOE_D || t == ETH_SKIP_C) begin
            d.verdict = ST_SKIP;
        end
        return d;
    endfunction

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_take      = !i_word.last_byte || w_slot_free;
    assign w_fire      = i_valid && o_take;

    always_comb begin
        n_shift   = {r_shift[BYTE_W-1:0], i_word.frame_byte};
        n_index   = (r_index == INDEX_MAX) ? r_index : r_index + 1'b1;
        n_stage   = r_stage;
        n_start   = r_start;
        n_len     = r_len;
        n_verdict = r_verdict;
        n_v6      = r_v6;
        w_dec     = decode_type(n_shift);
        // length field can sit past byte 31 behind two tags and pppoe
        w_len_idx = {1'b0, r_start} + {1'b0, (r_v6 ? IPV6_LEN_OFS : IPV4_LEN_OFS)};
        w_total   = {1'b0, n_shift} + {{(LEN_W-START_W){1'b0}}, r_start}
                    + (r_v6 ? IPV6_HDR_LEN : '0);

        unique case (r_stage)
            STG_OUTER: begin
                if (r_index == IDX_OUTER_TYPE) begin
                    if (n_shift == ETH_VLAN) begin
                        n_stage = STG_VLAN1;
                    end else if (n_shift == ETH_SKIP_A || n_shift == ETH_SKIP_B
                                 || n_shift == ETH_LLDP) begin
                        n_stage   = STG_DONE;
                        n_verdict = ST_SKIP;
                    end else begin
                        n_start   = POS_AFTER_MAC;
                        n_stage   = w_dec.stage;
                        n_verdict = (w_dec.stage == STG_DONE) ? w_dec.verdict : r_verdict;
                        if (w_dec.stage == STG_IP) n_v6 = w_dec.v6;
                    end
                end
            end
            STG_VLAN1: begin
                if (r_index == IDX_VLAN1_TYPE) begin
                    if (n_shift == ETH_VLAN) begin
                        n_stage = STG_VLAN2;
                    end else begin
                        n_start   = POS_AFTER_VLAN1;
                        n_stage   = w_dec.stage;
                        n_verdict = (w_dec.stage == STG_DONE) ? w_dec.verdict : r_verdict;
                        if (w_dec.stage == STG_IP) n_v6 = w_dec.v6;
                    end
                end
            end
            STG_VLAN2: begin
                if (r_index == IDX_VLAN2_TYPE) begin
                    n_start   = POS_AFTER_VLAN2;
                    n_stage   = w_dec.stage;
                    n_verdict = (w_dec.stage == STG_DONE) ? w_dec.verdict : r_verdict;
                    if (w_dec.stage == STG_IP) n_v6 = w_dec.v6;
                end
            end
            STG_PPP: begin
                if (r_index == {1'b0, r_start + PPPOE_PROTO_OFS}) begin
                    n_start = r_start + PPPOE_HDR_LEN;
                    if (n_shift == PPP_IPV4) begin
                        n_v6    = 1'b0;
                        n_stage = STG_IP;
                    end else if (n_shift == PPP_IPV6 || n_shift == PPP_IPV6CP) begin
                        n_v6    = 1'b1;
                        n_stage = STG_IP;
                    end else if (n_shift == PPP_LCP || n_shift == PPP_SKIP_A
                                 || n_shift == PPP_PAP || n_shift == PPP_SKIP_B
                                 || n_shift == PPP_IPCP) begin
                        n_stage   = STG_DONE;
                        n_verdict = ST_SKIP;
                    end else begin
                        n_stage   = STG_DONE;
                        n_verdict = ST_UNKNOWN;
                    end
                end
            end
            STG_IP: begin
                if (r_index == {1'b0, r_start}) begin
                    if (i_word.frame_byte[BYTE_W-1:4] != (r_v6 ? VER_SIX : VER_FOUR)) begin
                        n_stage   = STG_DONE;
                        n_verdict = ST_BADVER;
                    end
                end else if (r_index == w_len_idx) begin
                    n_stage = STG_DONE;
                    if (w_total >= i_max_len) begin
                        n_verdict = ST_TOOLONG;
                    end else begin
                        n_len     = w_total;
                        n_verdict = r_v6 ? ST_IPV6 : ST_IPV4;
                    end
                end
            end
            default: begin
            end
        endcase

        w_status   = (n_stage == STG_DONE) ? n_verdict : ST_TRUNC;
        n_out_word.status     = w_status;
        n_out_word.packet_len = (w_status == ST_IPV4 || w_status == ST_IPV6) ? n_len : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= '0;
            r_shift   <= '0;
            r_stage   <= STG_OUTER;
            r_start   <= '0;
            r_len     <= '0;
            r_verdict <= ST_TRUNC;
            r_v6      <= 1'b0;
        end else if (w_fire) begin
            if (i_word.last_byte) begin
                r_index   <= '0;
                r_shift   <= '0;
                r_stage   <= STG_OUTER;
                r_start   <= '0;
                r_len     <= '0;
                r_verdict <= ST_TRUNC;
                r_v6      <= 1'b0;
            end else begin
                r_index   <= n_index;
                r_shift   <= n_shift;
                r_stage   <= n_stage;
                r_start   <= n_start;
                r_len     <= n_len;
                r_verdict <= n_verdict;
                r_v6      <= n_v6;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= w_fire && i_word.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && i_word.last_byte) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- hdl/ethernet_ip_header_classifier.sv -----
// top level of the ethernet ip header classifier
//
//  channel  dir  handshake                  word
//  input    in   i_in_valid / o_in_stall    i_in_word  (frame_byte, last_byte)
//  result   out  o_out_valid / i_out_stall  o_out_word (status, packet_len)
//  config   in   i_cfg_we                   i_cfg_wdata (max_packet_len)
//
// one byte a cycle unless the input stalls: an input register feeds the parser,
// one result register follows, so a verdict is registered in the result register
// once the parser takes its last byte from the input register.
// reset clears the frame state and sets the length limit to 65536.
// a stalled result only holds back a last byte; other bytes keep flowing.
`timescale 1ns / 1ps

module ethernet_ip_header_classifier import ehc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    logic             r_in_valid;
    t_in_word         r_in_word;
    logic [LEN_W-1:0] r_max_len;
    logic             w_take;
    logic             w_accept;

    assign o_in_stall = r_in_valid && !w_take;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    ehc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_word      (r_in_word),
        .i_max_len   (r_max_len),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    a_len_zero_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_IPV4 && o_out_word.status != ST_IPV6
        |-> o_out_word.packet_len == '0)
        else $error("nonzero length on a rejected frame");

    a_len_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_IPV4 || o_out_word.status == ST_IPV6)
        |-> o_out_word.packet_len < r_max_len)
        else $error("accepted length at or above the limit");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_take && r_in_word.last_byte |=> o_out_valid)
        else $error("last byte consumed without a verdict");

    a_stall_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_word.last_byte && o_out_valid && i_out_stall)
        else $error("input stalled without a pending verdict");

endmodule

// ----- test/ehc_checker.sv -----
// checker that predicts the classifier verdicts and compares them with the result channel
`timescale 1ns / 1ps

module ehc_checker import ehc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_word         i_in_word,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_word        i_out_word,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output logic [6:0]       o_seen_mask
);

    localparam int PRINT_MAX = 30;

    logic [LEN_W-1:0]   limit_q;
    logic [INDEX_W-1:0] pos_cnt;
    logic [TYPE_W-1:0]  type_window;
    t_stage             stage_q;
    logic [START_W-1:0] hdr_start;
    logic [LEN_W-1:0]   len_calc;
    t_status            verdict_q;
    logic               ipv6_hdr;
    t_out_word          verdict_fifo[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_fail_count < PRINT_MAX)
            $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        o_fail_count++;
    endtask

    task automatic clear_frame_state();
        pos_cnt     = '0;
        type_window = '0;
        stage_q     = STG_OUTER;
        hdr_start   = '0;
        len_calc    = '0;
        verdict_q   = ST_TRUNC;
        ipv6_hdr    = 1'b0;
    endtask

    task automatic settle(input t_status code);
        verdict_q = code;
        stage_q   = STG_DONE;
    endtask

    // type field after the mac header or the vlan tags; pos is where the next header starts
    task automatic take_inner_type(input logic [TYPE_W-1:0] etype,
                                   input logic [START_W-1:0] pos);
        hdr_start = pos;
        if (etype == ETH_PPPOE_S) begin
            stage_q = STG_PPP;
        end else if (etype == ETH_IPV4) begin
            ipv6_hdr = 1'b0;
            stage_q  = STG_IP;
        end else if (etype == ETH_IPV6) begin
            ipv6_hdr = 1'b1;
            stage_q  = STG_IP;
        end else if (etype == ETH_ARP || etype == ETH_PPPOE_D || etype == ETH_SKIP_C) begin
            settle(ST_SKIP);
        end else begin
            settle(ST_UNKNOWN);
        end
    endtask

    task automatic classify_byte(input t_in_word w);
        int        idx;
        int        total;
        t_out_word res;
        idx = pos_cnt;
        type_window = {type_window[7:0], w.frame_byte};
        case (stage_q)
            STG_OUTER: begin
                if (idx == IDX_OUTER_TYPE) begin
                    if (type_window == ETH_VLAN)
                        stage_q = STG_VLAN1;
                    else if (type_window == ETH_SKIP_A || type_window == ETH_SKIP_B ||
                             type_window == ETH_LLDP)
                        settle(ST_SKIP);
                    else
                        take_inner_type(type_window, POS_AFTER_MAC);
                end
            end
            STG_VLAN1: begin
                if (idx == IDX_VLAN1_TYPE) begin
                    if (type_window == ETH_VLAN)
                        stage_q = STG_VLAN2;
                    else
                        take_inner_type(type_window, POS_AFTER_VLAN1);
                end
            end
            STG_VLAN2: begin
                if (idx == IDX_VLAN2_TYPE)
                    take_inner_type(type_window, POS_AFTER_VLAN2);
            end
            STG_PPP: begin
                // ppp protocol sits in the last two bytes of the 8-byte pppoe header
                if (idx == int'(hdr_start) + 7) begin
                    hdr_start = hdr_start + 5'd8;
                    if (type_window == PPP_IPV4) begin
                        ipv6_hdr = 1'b0;
                        stage_q  = STG_IP;
                    end else if (type_window == PPP_IPV6 || type_window == PPP_IPV6CP) begin
                        ipv6_hdr = 1'b1;
                        stage_q  = STG_IP;
                    end else if (type_window == PPP_LCP || type_window == PPP_SKIP_A ||
                                 type_window == PPP_PAP || type_window == PPP_SKIP_B ||
                                 type_window == PPP_IPCP) begin
                        settle(ST_SKIP);
                    end else begin
                        settle(ST_UNKNOWN);
                    end
                end
            end
            STG_IP: begin
                if (idx == int'(hdr_start)) begin
                    if (w.frame_byte[7:4] != (ipv6_hdr ? VER_SIX : VER_FOUR))
                        settle(ST_BADVER);
                end else if (idx == int'(hdr_start) + (ipv6_hdr ? 5 : 3)) begin
                    total = int'(type_window) + int'(hdr_start) + (ipv6_hdr ? 40 : 0);
                    if (total >= int'(limit_q)) begin
                        settle(ST_TOOLONG);
                    end else begin
                        len_calc = total[LEN_W-1:0];
                        settle(ipv6_hdr ? ST_IPV6 : ST_IPV4);
                    end
                end
            end
            default: ;
        endcase
        if (pos_cnt != INDEX_MAX)
            pos_cnt++;
        if (w.last_byte) begin
            res.status     = (stage_q == STG_DONE) ? verdict_q : ST_TRUNC;
            res.packet_len = (res.status == ST_IPV4 || res.status == ST_IPV6) ? len_calc : '0;
            verdict_fifo.push_back(res);
            clear_frame_state();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            limit_q = MAX_LEN_RESET;
            clear_frame_state();
            verdict_fifo.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_seen_mask  = '0;
        end else begin
            if (i_cfg_we)
                limit_q = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                classify_byte(i_in_word);
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (verdict_fifo.size() == 0) begin
                    report_mismatch("verdict with none pending, status", i_out_word.status, -1);
                end else begin
                    want = verdict_fifo.pop_front();
                    o_seen_mask[want.status] = 1'b1;
                    if (i_out_word.status !== want.status)
                        report_mismatch("status", i_out_word.status, want.status);
                    if (i_out_word.packet_len !== want.packet_len)
                        report_mismatch("packet_len", i_out_word.packet_len, want.packet_len);
                end
            end
        end
        o_pending = verdict_fifo.size();
    end

endmodule

// ----- test/tb_top.sv -----
// testbench top: frame stimulus, result stall pattern, watchdog and final verdict
`timescale 1ns / 1ps

module tb_top import ehc_pkg::*;;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_word         i_in_word   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_word        o_out_word;
    logic             i_cfg_we    = 1'b0;
    logic [LEN_W-1:0] i_cfg_wdata = '0;

    int         fail_count;
    int         pending;
    int         checked;
    logic [6:0] seen_mask;

    logic [7:0] frame_q[$];
    int         cur_limit    = 65536;
    int         burst_left   = 0;
    int         bytes_sent   = 0;
    int         frames_sent  = 0;
    int         limits_used  = 0;
    int         quiet_cycles = 0;
    int         hold_asks    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ethernet_ip_header_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ehc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_seen_mask  (seen_mask)
    );

    // ---------------------------------------------------------------- frame building

    task automatic push16(input logic [15:0] v);
        frame_q.push_back(v[15:8]);
        frame_q.push_back(v[7:0]);
    endtask

    task automatic start_frame(input int n_vlan);
        frame_q.delete();
        repeat (12) frame_q.push_back(8'($urandom_range(0, 255)));
        repeat (n_vlan) begin
            push16(ETH_VLAN);
            push16(16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic push_tail(input int n_tail);
        repeat (n_tail) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic trim_frame(input int keep);
        logic [7:0] junk;
        while (frame_q.size() > keep)
            junk = frame_q.pop_back();
    endtask

    // ip length field: anywhere, typical sizes, or right around the current limit
    function automatic logic [15:0] pick_ip_len(input int hdr_off);
        int r;
        int t;
        int jitter;
        r = $urandom_range(0, 9);
        jitter = $urandom_range(0, 4);
        if (r < 3)
            t = $urandom_range(0, 65535);
        else if (r < 6)
            t = $urandom_range(0, 1500);
        else
            t = cur_limit - hdr_off + jitter - 2;
        if (t < 0)
            t = 0;
        if (t > 65535)
            t = 65535;
        return t[15:0];
    endfunction

    // ip_len below zero picks a random length
    task automatic build_ip_frame(input int n_vlan, input bit pppoe, input bit v6,
                                  input bit alt_proto, input bit bad_ver, input int ip_len,
                                  input int n_tail);
        int          off;
        logic [3:0]  ver;
        logic [3:0]  low;
        logic [15:0] len16;
        start_frame(n_vlan);
        off = 14 + 4 * n_vlan;
        if (pppoe) begin
            push16(ETH_PPPOE_S);
            push_tail(6);
            push16(v6 ? (alt_proto ? PPP_IPV6CP : PPP_IPV6) : PPP_IPV4);
            off += 8;
        end else begin
            push16(v6 ? ETH_IPV6 : ETH_IPV4);
        end
        ver = v6 ? VER_SIX : VER_FOUR;
        if (bad_ver)
            ver = ver ^ 4'($urandom_range(1, 15));
        low = 4'($urandom_range(0, 15));
        len16 = (ip_len < 0) ? pick_ip_len(off + (v6 ? 40 : 0)) : ip_len[15:0];
        frame_q.push_back({ver, low});
        push_tail(v6 ? 3 : 1);
        push16(len16);
        push_tail(n_tail);
    endtask

    task automatic build_typed_frame(input int n_vlan, input logic [15:0] etype,
                                     input int n_tail);
        start_frame(n_vlan);
        push16(etype);
        push_tail(n_tail);
    endtask

    task automatic build_ppp_frame(input int n_vlan, input logic [15:0] proto,
                                   input int n_tail);
        start_frame(n_vlan);
        push16(ETH_PPPOE_S);
        push_tail(6);
        push16(proto);
        push_tail(n_tail);
    endtask

    task automatic random_frame();
        int          r;
        int          nv;
        int          tail;
        logic [15:0] et;
        r = $urandom_range(0, 99);
        nv = $urandom_range(0, 2);
        tail = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 6);
        if (r < 55) begin
            build_ip_frame(nv, $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), $urandom_range(0, 11) == 0, -1, tail);
        end else if (r < 62) begin
            case ($urandom_range(0, 2))
                0:       et = ETH_SKIP_A;
                1:       et = ETH_SKIP_B;
                default: et = ETH_LLDP;
            endcase
            build_typed_frame(0, et, tail);
        end else if (r < 72) begin
            case ($urandom_range(0, 6))
                0:       et = ETH_ARP;
                1:       et = ETH_PPPOE_D;
                2:       et = ETH_SKIP_C;
                3:       et = ETH_VLAN;
                4:       et = ETH_LLDP;
                5:       et = ETH_SKIP_A;
                default: et = 16'($urandom_range(0, 65535));
            endcase
            build_typed_frame(nv, et, tail);
        end else if (r < 80) begin
            case ($urandom_range(0, 5))
                0:       et = PPP_LCP;
                1:       et = PPP_SKIP_A;
                2:       et = PPP_PAP;
                3:       et = PPP_SKIP_B;
                4:       et = PPP_IPCP;
                default: et = 16'($urandom_range(0, 65535));
            endcase
            build_ppp_frame(nv, et, tail);
        end else if (r < 92) begin
            // frame cut short somewhere, possibly after its verdict
            build_ip_frame(nv, $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'b0, -1, 0);
            trim_frame($urandom_range(1, frame_q.size()));
        end else begin
            frame_q.delete();
            repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------- driving

    task automatic send_word(input logic [7:0] b, input logic last);
        int       gap;
        t_in_word w;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        w.frame_byte = b;
        w.last_byte  = last;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame();
        int n;
        for (n = 0; n < frame_q.size(); n++)
            send_word(frame_q[n], n == frame_q.size() - 1);
        frames_sent++;
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge i_clk);
        while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [LEN_W-1:0] v);
        wait_results_done();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        cur_limit = int'(v);
        limits_used++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        build_ip_frame(0, 0, 0, 0, 0, 20, 0);      send_frame(); // ends on the length byte
        build_ip_frame(0, 0, 1, 0, 0, 0, 4);       send_frame();
        build_ip_frame(1, 0, 0, 0, 0, 65535, 2);   send_frame();
        build_ip_frame(2, 0, 1, 0, 0, 100, 1);     send_frame();
        build_ip_frame(0, 1, 0, 0, 0, 1000, 3);    send_frame();
        build_ip_frame(1, 1, 1, 0, 0, 200, 0);     send_frame();
        build_ip_frame(2, 1, 1, 1, 0, 300, 0);     send_frame();
        build_ip_frame(2, 1, 0, 0, 0, 500, 0);     send_frame();
        // one below and exactly at the reset limit
        build_ip_frame(0, 0, 0, 0, 0, 65521, 0);   send_frame();
        build_ip_frame(0, 0, 0, 0, 0, 65522, 0);   send_frame();
        build_ip_frame(0, 0, 0, 0, 1, 40, 2);      send_frame();
        build_ip_frame(1, 1, 1, 0, 1, 40, 2);      send_frame();
        build_typed_frame(0, ETH_SKIP_A, 2);       send_frame();
        build_typed_frame(0, ETH_SKIP_B, 0);       send_frame();
        build_typed_frame(0, ETH_LLDP, 1);         send_frame();
        build_typed_frame(1, ETH_ARP, 0);          send_frame();
        build_typed_frame(0, ETH_PPPOE_D, 1);      send_frame();
        build_typed_frame(2, ETH_SKIP_C, 0);       send_frame();
        build_typed_frame(2, ETH_VLAN, 4);         send_frame(); // third tag
        build_typed_frame(1, ETH_LLDP, 0);         send_frame(); // outer-only skip behind a tag
        build_typed_frame(0, 16'h1234, 0);         send_frame();
        build_ppp_frame(0, PPP_LCP, 0);            send_frame();
        build_ppp_frame(1, PPP_SKIP_A, 1);         send_frame();
        build_ppp_frame(2, PPP_PAP, 0);            send_frame();
        build_ppp_frame(0, PPP_SKIP_B, 2);         send_frame();
        build_ppp_frame(0, PPP_IPCP, 0);           send_frame();
        build_ppp_frame(1, 16'hffff, 0);           send_frame();
        frame_q.delete();
        frame_q.push_back(8'h81);                  send_frame(); // single-byte frame
        build_ip_frame(1, 1, 0, 0, 0, 60, 0);
        trim_frame(frame_q.size() - 1);            send_frame(); // stops inside the length field
        build_ip_frame(0, 0, 0, 0, 0, 60, 50);     send_frame(); // byte index saturates
    endtask

    task automatic run_random(input int quota, input bit with_hold);
        int start_bytes;
        int nfr;
        start_bytes = bytes_sent;
        nfr = 0;
        while (bytes_sent - start_bytes < quota || nfr < 8) begin
            if (with_hold && nfr == 3)
                hold_asks++;
            random_frame();
            send_frame();
            nfr++;
        end
    endtask

    // ---------------------------------------------------------------- result side stall

    initial begin : result_stall
        int mode;
        int span_left;
        int hold_left;
        int holds_done;
        int k;
        mode = 0;
        span_left = 0;
        hold_left = 0;
        holds_done = 0;
        k = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_asks > holds_done) begin
                // long hold-off so the parser backs up into the input channel
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                if (span_left == 0) begin
                    mode = $urandom_range(0, 3);
                    span_left = $urandom_range(20, 120);
                end
                span_left--;
                k++;
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= k[1];
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        set_limit(17'd131071);
        build_ip_frame(2, 1, 1, 1, 0, 65535, 0); // largest length that can pass
        send_frame();
        run_random(190, 1'b0);
        set_limit(17'd1);
        run_random(190, 1'b0);
        set_limit(17'($urandom_range(41, 2000)));
        run_random(190, 1'b1);
        set_limit(MAX_LEN_RESET);
        run_random(190, 1'b0);
        set_limit(17'($urandom_range(1, 131071)));
        run_random(190, 1'b0);
        wait_results_done();
        repeat (8) @(posedge i_clk);
        $display("run covered %0d bytes in %0d frames under %0d written length limits",
                 bytes_sent, frames_sent, limits_used);
        $display("%0d verdicts compared, status codes seen (bit per code) %b",
                 checked, seen_mask);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ehc_pkg.sv
hdl/ehc_parser.sv
hdl/ethernet_ip_header_classifier.sv
test/ehc_checker.sv
test/tb_top.sv
